// File: design/mwm_pkg.sv
// mecanum wheel mixer package: sizes, item types and helper functions
// shared by the front, the queue and the back of the mixer
// no dependencies

package mwm_pkg;

    // drive limit that every command and every wheel speed is held to
    localparam int DRIVE_LIMIT = 100;

    // field widths
    localparam int CMD_W    = 16;
    localparam int WHEEL_W  = 8;
    localparam int WHEELS   = 4;

    // saturated command, mixed wheel value and its magnitude
    localparam int LIM_W    = $clog2(DRIVE_LIMIT + 1) + 1;
    localparam int MAG_W    = $clog2(3 * DRIVE_LIMIT + 1);
    localparam int MIX_W    = MAG_W + 1;

    // rescale divider: quotient bits and dividend width
    localparam int QUO_W    = $clog2(DRIVE_LIMIT + 1);
    localparam int DVD_W    = MAG_W + QUO_W;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // wheel lanes in physical channel order
    localparam int WHEEL_FR = 0;
    localparam int WHEEL_FL = 1;
    localparam int WHEEL_BL = 2;
    localparam int WHEEL_BR = 3;

    // mixed item handed from front to back
    typedef struct packed {
        logic [WHEELS-1:0][MIX_W-1:0] wheel;
        logic [MAG_W-1:0]             peak;
        logic                         scale;
    } mix_item_t;

    // one stage of the rescale divider
    typedef struct packed {
        logic [WHEELS-1:0]            neg;
        logic [WHEELS-1:0][MIX_W-1:0] wheel;
        logic [WHEELS-1:0][DVD_W-1:0] dvd;
        logic [WHEELS-1:0][MAG_W-1:0] rem;
        logic [WHEELS-1:0][QUO_W-1:0] quo;
        logic [MAG_W-1:0]             peak;
        logic                         scale;
    } div_stage_t;

    // clamp a command to plus or minus the drive limit
    function automatic logic signed [LIM_W-1:0] sat_cmd(input logic signed [CMD_W-1:0] v);
        logic signed [CMD_W-1:0] lim;
        lim = CMD_W'(DRIVE_LIMIT);
        if (v > lim)
            return LIM_W'(DRIVE_LIMIT);
        else if (v < -lim)
            return -LIM_W'(DRIVE_LIMIT);
        else
            return LIM_W'(v);
    endfunction

    // magnitude of a mixed wheel value
    function automatic logic [MAG_W-1:0] mag_of(input logic signed [MIX_W-1:0] v);
        logic signed [MIX_W-1:0] n;
        n = -v;
        return v[MIX_W-1] ? MAG_W'(n) : MAG_W'(v);
    endfunction

    // low byte of the two's complement wheel value
    function automatic logic [WHEEL_W-1:0] to_field8(input logic signed [MIX_W-1:0] v);
        logic signed [31:0] w;
        w = 32'(v);
        return w[WHEEL_W-1:0];
    endfunction

endpackage

// File: design/mwm_front.sv
// mixer front: clamps the commands, mixes four wheel values and finds the peak
// depends on mwm_pkg

module mwm_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [mwm_pkg::CMD_W-1:0] forward_cmd,
    input  logic signed [mwm_pkg::CMD_W-1:0] strafe_cmd,
    input  logic signed [mwm_pkg::CMD_W-1:0] yaw_cmd,
    output logic                            out_valid,
    input  logic                            out_ready,
    output mwm_pkg::mix_item_t              out_item
);

    logic signed [mwm_pkg::LIM_W-1:0] x_sat, y_sat, w_sat;
    logic signed [mwm_pkg::MIX_W-1:0] x_ext, y_ext, w_ext;
    logic signed [mwm_pkg::MIX_W-1:0] fr, fl, bl, br;
    logic [mwm_pkg::MAG_W-1:0]        mag_fr, mag_fl, mag_bl, mag_br;
    logic [mwm_pkg::MAG_W-1:0]        max_a, max_b, peak;
    mwm_pkg::mix_item_t               item_next;
    mwm_pkg::mix_item_t               item_reg;
    logic                             valid_reg;

    // clamp and mix
    always_comb
    begin
        x_sat = mwm_pkg::sat_cmd(forward_cmd);
        y_sat = mwm_pkg::sat_cmd(strafe_cmd);
        w_sat = mwm_pkg::sat_cmd(yaw_cmd);
        x_ext = mwm_pkg::MIX_W'(x_sat);
        y_ext = mwm_pkg::MIX_W'(y_sat);
        w_ext = mwm_pkg::MIX_W'(w_sat);
        fl = x_ext + y_ext + w_ext;
        fr = x_ext - y_ext - w_ext;
        bl = x_ext - y_ext + w_ext;
        br = x_ext + y_ext - w_ext;
    end

    // largest magnitude over a two-level compare tree
    always_comb
    begin
        mag_fr = mwm_pkg::mag_of(fr);
        mag_fl = mwm_pkg::mag_of(fl);
        mag_bl = mwm_pkg::mag_of(bl);
        mag_br = mwm_pkg::mag_of(br);
        max_a  = (mag_fr > mag_fl) ? mag_fr : mag_fl;
        max_b  = (mag_bl > mag_br) ? mag_bl : mag_br;
        peak   = (max_a > max_b) ? max_a : max_b;
    end

    // item in physical channel order
    always_comb
    begin
        item_next.wheel[mwm_pkg::WHEEL_FR] = fr;
        item_next.wheel[mwm_pkg::WHEEL_FL] = fl;
        item_next.wheel[mwm_pkg::WHEEL_BL] = bl;
        item_next.wheel[mwm_pkg::WHEEL_BR] = br;
        item_next.peak  = peak;
        item_next.scale = (peak > mwm_pkg::MAG_W'(mwm_pkg::DRIVE_LIMIT));
    end

    // output register, refilled whenever it empties or is taken
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// File: design/mwm_queue.sv
// short queue of mixed items between the front and the back
// depends on mwm_pkg

module mwm_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mwm_pkg::mix_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output mwm_pkg::mix_item_t out_item
);

    mwm_pkg::mix_item_t               entry_reg [mwm_pkg::QUEUE_DEPTH];
    logic [mwm_pkg::QPTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [mwm_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                             push, pop;

    assign in_ready  = (count_reg != mwm_pkg::QCNT_W'(mwm_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = entry_reg[rd_ptr_reg];

    // fill count
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == mwm_pkg::QPTR_W'(mwm_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == mwm_pkg::QPTR_W'(mwm_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= in_item;
    end

endmodule

// File: design/mwm_back.sv
// mixer back: pipelined restoring divider that rescales the wheels by limit/peak,
// one quotient bit per stage for all four wheels, then the output register
// depends on mwm_pkg

module mwm_back (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  mwm_pkg::mix_item_t                           in_item,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output logic [mwm_pkg::WHEELS-1:0][mwm_pkg::WHEEL_W-1:0] out_wheel
);

    mwm_pkg::div_stage_t stage_next [mwm_pkg::QUO_W+1];
    mwm_pkg::div_stage_t stage_reg  [mwm_pkg::QUO_W+1];
    logic [mwm_pkg::QUO_W:0]                               valid_reg;
    logic [mwm_pkg::WHEELS-1:0][mwm_pkg::WHEEL_W-1:0]      wheel_next, wheel_reg;
    logic                                                  out_valid_reg;
    logic                                                  advance;

    // the whole pipeline moves unless a finished item waits at the output
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    // load stage: split sign, scale the magnitude by the limit
    always_comb
    begin
        stage_next[0].wheel = in_item.wheel;
        stage_next[0].peak  = in_item.peak;
        stage_next[0].scale = in_item.scale;
        for (int l = 0; l < mwm_pkg::WHEELS; l++)
        begin
            stage_next[0].neg[l] = in_item.wheel[l][mwm_pkg::MIX_W-1];
            stage_next[0].dvd[l] = mwm_pkg::DVD_W'(mwm_pkg::mag_of(in_item.wheel[l]))
                                   * mwm_pkg::DVD_W'(mwm_pkg::DRIVE_LIMIT);
            stage_next[0].rem[l] = stage_next[0].dvd[l][mwm_pkg::DVD_W-1:mwm_pkg::QUO_W];
            stage_next[0].quo[l] = '0;
        end
    end

    // divider stages, one quotient bit each
    for (genvar s = 1; s <= mwm_pkg::QUO_W; s++)
    begin : g_div
        always_comb
        begin
            logic [mwm_pkg::MAG_W:0] trial;
            logic [mwm_pkg::MAG_W:0] divisor;
            stage_next[s] = stage_reg[s-1];
            divisor = {1'b0, stage_reg[s-1].peak};
            for (int l = 0; l < mwm_pkg::WHEELS; l++)
            begin
                trial = {stage_reg[s-1].rem[l], stage_reg[s-1].dvd[l][mwm_pkg::QUO_W-s]};
                if (trial >= divisor)
                begin
                    stage_next[s].rem[l] = mwm_pkg::MAG_W'(trial - divisor);
                    stage_next[s].quo[l] = (stage_reg[s-1].quo[l] << 1) | mwm_pkg::QUO_W'(1);
                end
                else
                begin
                    stage_next[s].rem[l] = mwm_pkg::MAG_W'(trial);
                    stage_next[s].quo[l] = stage_reg[s-1].quo[l] << 1;
                end
            end
        end
    end

    // put the sign back on the quotient, or pass the wheel through
    always_comb
    begin
        logic signed [mwm_pkg::MIX_W-1:0] q;
        logic signed [mwm_pkg::MIX_W-1:0] v;
        for (int l = 0; l < mwm_pkg::WHEELS; l++)
        begin
            q = mwm_pkg::MIX_W'(stage_reg[mwm_pkg::QUO_W].quo[l]);
            if (stage_reg[mwm_pkg::QUO_W].scale)
                v = stage_reg[mwm_pkg::QUO_W].neg[l] ? -q : q;
            else
                v = stage_reg[mwm_pkg::QUO_W].wheel[l];
            wheel_next[l] = mwm_pkg::to_field8(v);
        end
    end

    // stage valids and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg     <= {valid_reg[mwm_pkg::QUO_W-1:0], in_valid};
            out_valid_reg <= valid_reg[mwm_pkg::QUO_W];
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int s = 0; s <= mwm_pkg::QUO_W; s++)
                stage_reg[s] <= stage_next[s];
            wheel_reg <= wheel_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_wheel = wheel_reg;

endmodule

// File: design/mecanum_wheel_mixer_core.sv
// mecanum wheel mixer top level: front, queue and rescale back end
// depends on mwm_pkg, mwm_front, mwm_queue, mwm_back
//
// usage
//   s_axis carries one drive command per item: forward, strafe and yaw, each
//   signed 16 bits. m_axis returns one item per command with the four wheel
//   speeds in physical channel order fr, fl, bl, br, signed 8 bits each.
//   commands are clamped to the drive limit, mixed, and if the largest wheel
//   magnitude is above the limit all wheels are scaled by limit/peak with
//   truncation toward zero.
// timing
//   from accept to output valid an item passes the front register, a queue
//   slot, the divider load stage, one divider stage per quotient bit, and the
//   output register. one item is accepted every cycle unless the front
//   register and the queue are both full; the divider is a pipeline, one
//   quotient bit per stage across all four wheels.
// reset and stall
//   reset empties the front register, the queue and the divider pipeline.
//   when m_axis stalls the divider pipeline holds, the queue fills, and
//   s_axis_tready drops once the front register and the queue are both full.

module mecanum_wheel_mixer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] forward_cmd, [31:16] strafe_cmd, [47:32] yaw_cmd
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] wheel_front_right, [15:8] wheel_front_left,
    // [23:16] wheel_back_left, [31:24] wheel_back_right
    output logic [31:0] m_axis_tdata
);

    logic                 front_valid, queue_ready;
    mwm_pkg::mix_item_t   front_item;
    logic                 queue_valid, back_ready;
    mwm_pkg::mix_item_t   queue_item;
    logic [mwm_pkg::WHEELS-1:0][mwm_pkg::WHEEL_W-1:0] wheel;

    // clamp, mix, peak
    mwm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .forward_cmd (s_axis_tdata[15:0]),
        .strafe_cmd  (s_axis_tdata[31:16]),
        .yaw_cmd     (s_axis_tdata[47:32]),
        .out_valid   (front_valid),
        .out_ready   (queue_ready),
        .out_item    (front_item)
    );

    // decoupling queue
    mwm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (queue_ready),
        .in_item   (front_item),
        .out_valid (queue_valid),
        .out_ready (back_ready),
        .out_item  (queue_item)
    );

    // rescale divider and output register
    mwm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (queue_valid),
        .in_ready  (back_ready),
        .in_item   (queue_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_wheel (wheel)
    );

    assign m_axis_tdata = wheel;

    // every wheel speed within the drive limit whenever the limit fits a byte
    logic wheels_in_range;

    always_comb
    begin
        wheels_in_range = 1'b1;
        for (int l = 0; l < mwm_pkg::WHEELS; l++)
        begin
            if ($signed(wheel[l]) > $signed(mwm_pkg::WHEEL_W'(mwm_pkg::DRIVE_LIMIT))
                || $signed(wheel[l]) < -$signed(mwm_pkg::WHEEL_W'(mwm_pkg::DRIVE_LIMIT)))
                wheels_in_range = 1'b0;
        end
    end

    // wheel speeds on m_axis never leave the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (mwm_pkg::DRIVE_LIMIT <= 127)) |-> wheels_in_range)
        else $error("wheel speed beyond drive limit");

    // a held front item with a full queue must block new commands
    assert property (@(posedge clk) disable iff (!rst_n)
        (front_valid && !queue_ready) |-> !s_axis_tready)
        else $error("command accepted while front item is blocked");

    // the back end takes from the queue only when its pipeline can move
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !back_ready)
        else $error("divider advanced while output is stalled");

endmodule

// File: sim/wheel_speed_checker.sv
// wheel speed checker for the mecanum wheel mixer: predicts the four wheel
// speeds of every accepted drive command and compares them with the output items
// depends on mwm_pkg for the drive limit and the wheel lane layout
`timescale 1ns / 100ps

module wheel_speed_checker
    import mwm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  logic        cmd_ready,
    // [15:0] forward_cmd, [31:16] strafe_cmd, [47:32] yaw_cmd
    input  logic [47:0] cmd_data,
    input  logic        speed_valid,
    input  logic        speed_ready,
    // [7:0] front right, [15:8] front left, [23:16] back left, [31:24] back right
    input  logic [31:0] speed_data,
    output int          mismatch_count,
    output int          speeds_pending,
    output int          speeds_checked
);

    logic [31:0] expected_speeds[$];
    string       lane_name[WHEELS] = '{"front_right", "front_left", "back_left", "back_right"};

    // saturate one signed command to the drive limit
    function automatic int clamp_to_limit(input logic signed [CMD_W-1:0] v);
        int s;
        s = v;
        if (s > DRIVE_LIMIT)
            return DRIVE_LIMIT;
        if (s < -DRIVE_LIMIT)
            return -DRIVE_LIMIT;
        return s;
    endfunction

    // mix a command into four wheel speeds, rescaled if the peak tops the limit
    function automatic logic [31:0] mix_wheel_speeds(input logic [47:0] cmd);
        int          x;
        int          y;
        int          w;
        int          peak;
        int          speed[WHEELS];
        logic [31:0] lanes;
        x = clamp_to_limit(cmd[15:0]);
        y = clamp_to_limit(cmd[31:16]);
        w = clamp_to_limit(cmd[47:32]);
        speed[WHEEL_FL] = x + y + w;
        speed[WHEEL_FR] = x - y - w;
        speed[WHEEL_BL] = x - y + w;
        speed[WHEEL_BR] = x + y - w;
        peak = 0;
        for (int i = 0; i < WHEELS; i++)
        begin
            if ((speed[i] < 0 ? -speed[i] : speed[i]) > peak)
                peak = speed[i] < 0 ? -speed[i] : speed[i];
        end
        // integer division truncates toward zero on both signs
        if (peak > DRIVE_LIMIT)
        begin
            for (int i = 0; i < WHEELS; i++)
                speed[i] = (speed[i] * DRIVE_LIMIT) / peak;
        end
        for (int i = 0; i < WHEELS; i++)
            lanes[i*WHEEL_W +: WHEEL_W] = speed[i][WHEEL_W-1:0];
        return lanes;
    endfunction

    initial
    begin
        mismatch_count = 0;
        speeds_pending = 0;
        speeds_checked = 0;
    end

    // compare outgoing items first, then record the newly accepted command
    always @(posedge clk)
    begin : watch_channels
        logic        [31:0]        want;
        logic signed [WHEEL_W-1:0] want_lane;
        logic signed [WHEEL_W-1:0] got_lane;
        if (rst_n)
        begin
            if (speed_valid && speed_ready)
            begin
                if (expected_speeds.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected wheel speed item, expected none, actual %h",
                             $time, speed_data);
                end
                else
                begin
                    want = expected_speeds.pop_front();
                    speeds_checked++;
                    for (int i = 0; i < WHEELS; i++)
                    begin
                        want_lane = want[i*WHEEL_W +: WHEEL_W];
                        got_lane  = speed_data[i*WHEEL_W +: WHEEL_W];
                        if (got_lane !== want_lane)
                        begin
                            mismatch_count++;
                            $display("%0t: %s mismatch, expected %0d, actual %0d",
                                     $time, lane_name[i], want_lane, got_lane);
                        end
                    end
                end
            end
            if (cmd_valid && cmd_ready)
                expected_speeds.push_back(mix_wheel_speeds(cmd_data));
            speeds_pending = expected_speeds.size();
        end
    end

endmodule

// File: sim/tb_mecanum_wheel_mixer_core.sv
// testbench top for the mecanum wheel mixer: drives directed and random drive
// commands with random idling on both streams and reports the verdict
// depends on mwm_pkg, mecanum_wheel_mixer_core and wheel_speed_checker
`timescale 1ns / 100ps

module tb_mecanum_wheel_mixer_core;

    localparam int RANDOM_CMDS    = 800;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 1000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    logic        idling_on = 1'b1;
    int          directed_cmds = 0;
    int          idle_cycles = 0;
    int          mismatch_count;
    int          speeds_pending;
    int          speeds_checked;

    mecanum_wheel_mixer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    wheel_speed_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (s_axis_tvalid),
        .cmd_ready      (s_axis_tready),
        .cmd_data       (s_axis_tdata),
        .speed_valid    (m_axis_tvalid),
        .speed_ready    (m_axis_tready),
        .speed_data     (m_axis_tdata),
        .mismatch_count (mismatch_count),
        .speeds_pending (speeds_pending),
        .speeds_checked (speeds_checked)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stalls at random while idling is enabled
    always @(negedge clk)
        m_axis_tready <= !idling_on || ($urandom_range(99) >= 8);

    // watchdog on cycles where neither stream moves an item
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("** mecanum_wheel_mixer_core: FAILED **");
                $finish;
            end
        end
    end

    function automatic logic [47:0] pack_cmd(input int fwd, input int side, input int yaw);
        return {16'(yaw), 16'(side), 16'(fwd)};
    endfunction

    // mostly in-range values, some near the limit, some over the full field
    function automatic logic [15:0] random_axis();
        int pick;
        int v;
        pick = $urandom_range(99);
        if (pick < 60)
            v = int'($urandom_range(200)) - 100;
        else if (pick < 80)
        begin
            v = $urandom_range(110, 95);
            if ($urandom_range(1))
                v = -v;
        end
        else
            v = $urandom;
        return 16'(v);
    endfunction

    // offer one command, idling first at random; called and returns at a falling edge
    task automatic send_cmd(input logic [47:0] cmd);
        while (idling_on && $urandom_range(99) < 8)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {$urandom, $urandom};
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_directed(input int fwd, input int side, input int yaw);
        send_cmd(pack_cmd(fwd, side, yaw));
        directed_cmds++;
    endtask

    task automatic wait_all_speeds();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (speeds_pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // field extremes, clamping, exact limit, rescale with both signs
        send_directed(0, 0, 0);
        send_directed(32767, 0, 0);
        send_directed(-32768, 0, 0);
        send_directed(0, 32767, 0);
        send_directed(0, -32768, 0);
        send_directed(0, 0, 32767);
        send_directed(0, 0, -32768);
        send_directed(32767, 32767, 32767);
        send_directed(-32768, -32768, -32768);
        send_directed(100, 0, 0);
        send_directed(101, -101, 0);
        send_directed(-100, -100, -100);
        send_directed(100, 100, 100);
        send_directed(100, -100, 0);
        send_directed(50, 30, 20);
        send_directed(50, 30, 21);
        send_directed(-50, -30, -21);
        send_directed(-70, -20, -30);
        send_directed(33, -33, 34);
        send_directed(-1, 0, 0);
        send_directed(1, 1, 1);
        send_directed(100, 100, -100);
        send_directed(-32768, 32767, 1);
        send_directed(7, -99, 98);

        // random traffic: idling, a drain pause, a back-to-back stretch, idling again
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            if (n == RANDOM_CMDS / 4)
                wait_all_speeds();
            if (n == RANDOM_CMDS / 4)
                idling_on <= 1'b0;
            if (n == RANDOM_CMDS / 2)
                idling_on <= 1'b1;
            send_cmd({random_axis(), random_axis(), random_axis()});
        end

        wait_all_speeds();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d directed and %0d random drive commands, %0d wheel speed items",
                 directed_cmds, RANDOM_CMDS, speeds_checked);
        $display("with random stalls on both streams, a drain pause and a back-to-back stretch");
        if (mismatch_count == 0)
            $display("** mecanum_wheel_mixer_core: PASSED **");
        else
            $display("** mecanum_wheel_mixer_core: FAILED **");
        $finish;
    end

endmodule
